// ===== rtl/dpf_pkg.sv =====
`timescale 1ns / 1ps
package dpf_pkg;

  localparam int ANGLE_W    = 14;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] SYNC_BYTE  = 8'hCC;
  localparam logic [7:0] FRAME_LAST = 8'(255 - 1);

  typedef struct packed {
    logic [15:0]        counter_word;
    logic [ANGLE_W-1:0] angle_word;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last;
  } out_item_t;

  // One frame worth of payload, handed from the front end to the serializer.
  typedef struct packed {
    logic [15:0] dn;
    logic [15:0] du;
    logic [7:0]  number;
    logic [7:0]  checksum;
  } frame_t;

  typedef enum logic [6:0] {
    SLOT_SYNC  = 7'b0000001,
    SLOT_DN_LO = 7'b0000010,
    SLOT_DN_HI = 7'b0000100,
    SLOT_DU_LO = 7'b0001000,
    SLOT_DU_HI = 7'b0010000,
    SLOT_NUM   = 7'b0100000,
    SLOT_SUM   = 7'b1000000
  } slot_t;

endpackage

// ===== rtl/delta_packet_framer.sv =====
`timescale 1ns / 1ps
// Channel   Handshake          Payload
// sample    push / full        in_item_t  {counter_word, angle_word}
// result    pop / empty        out_item_t {tx_byte, last}
// config    cfg_we             cfg_wdata (angle mode)
//
// A sample becomes seven result beats, one per cycle while pop is held, so the
// byte-wide serializer sets the sustained rate; new samples are still taken
// while a frame is sent. A four-frame queue sits between the front end and
// the serializer; full rises only when it holds four unsent frames.
// Reset is synchronous and clears all history, the frame number and angle mode.
// A stalled pop holds the current byte; pushes continue until the queue fills.
module delta_packet_framer (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  dpf_pkg::in_item_t  sample,
  input  logic               pop,
  output logic               empty,
  output dpf_pkg::out_item_t result,
  input  logic               cfg_we,
  input  logic               cfg_wdata
);

  dpf_pkg::frame_t wr_frame;
  dpf_pkg::frame_t rd_frame;
  logic            accept;
  logic            fifo_valid;
  logic            fifo_rd;

  assign accept = push && !full;

  dpf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .sample    (sample),
    .frame     (wr_frame)
  );

  dpf_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (accept),
    .wr_data (wr_frame),
    .full    (full),
    .rd      (fifo_rd),
    .rd_data (rd_frame),
    .valid   (fifo_valid)
  );

  dpf_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .fifo_valid (fifo_valid),
    .fifo_data  (rd_frame),
    .fifo_rd    (fifo_rd),
    .frame_byte (result),
    .empty      (empty),
    .pop        (pop)
  );

endmodule

// ===== rtl/dpf_front.sv =====
`timescale 1ns / 1ps
module dpf_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              accept,
  input  dpf_pkg::in_item_t sample,
  output dpf_pkg::frame_t   frame
);

  logic        angle_mode;
  logic [15:0] count_now;
  logic [15:0] angle_now;
  logic [15:0] angle_before;
  logic [7:0]  frame_number;

  logic [15:0] angle_ext;
  logic [15:0] angle_now_next;
  logic [15:0] angle_before_next;
  logic [7:0]  frame_number_next;
  logic [15:0] dn;
  logic [15:0] du;

  always_comb begin
    angle_ext = {{(16 - dpf_pkg::ANGLE_W){sample.angle_word[dpf_pkg::ANGLE_W-1]}},
                 sample.angle_word};
    if (angle_mode) begin
      angle_now_next    = angle_ext;
      angle_before_next = angle_now;
    end else begin
      angle_now_next    = angle_now;
      angle_before_next = angle_before;
    end
    dn = sample.counter_word - count_now;
    du = angle_now_next - angle_before_next;
    frame_number_next = (frame_number == dpf_pkg::FRAME_LAST) ? 8'd0 : frame_number + 8'd1;
    frame.dn       = dn;
    frame.du       = du;
    frame.number   = frame_number_next;
    frame.checksum = dn[7:0] + dn[15:8] + du[7:0] + du[15:8] + frame_number_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_mode   <= 1'b0;
      count_now    <= '0;
      angle_now    <= '0;
      angle_before <= '0;
      frame_number <= '0;
    end else begin
      if (cfg_we) begin
        angle_mode <= cfg_wdata;
      end
      if (accept) begin
        count_now    <= sample.counter_word;
        angle_now    <= angle_now_next;
        angle_before <= angle_before_next;
        frame_number <= frame_number_next;
      end
    end
  end

`ifndef ASSERT_OFF
  // With angle mode off the stored angles must not move on a beat.
  a_angle_hold: assert property (@(posedge clk) disable iff (rst)
    accept && !angle_mode |=> $stable(angle_now) && $stable(angle_before))
    else $error("angle state changed with angle mode off");
`endif

endmodule

// ===== rtl/dpf_fifo.sv =====
`timescale 1ns / 1ps
module dpf_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  dpf_pkg::frame_t wr_data,
  output logic            full,
  input  logic            rd,
  output dpf_pkg::frame_t rd_data,
  output logic            valid
);

  dpf_pkg::frame_t               mem [dpf_pkg::FIFO_DEPTH];
  logic [dpf_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [dpf_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [dpf_pkg::FIFO_CW-1:0]   count;

  assign full    = (count == dpf_pkg::FIFO_CW'(dpf_pkg::FIFO_DEPTH));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (rd && !wr) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr |-> !full)
    else $error("frame queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    rd |-> valid)
    else $error("frame queue read while empty");
`endif

endmodule

// ===== rtl/dpf_serializer.sv =====
`timescale 1ns / 1ps
module dpf_serializer (
  input  logic               clk,
  input  logic               rst,
  input  logic               fifo_valid,
  input  dpf_pkg::frame_t    fifo_data,
  output logic               fifo_rd,
  output dpf_pkg::out_item_t frame_byte,
  output logic               empty,
  input  logic               pop
);

  logic            busy;
  dpf_pkg::slot_t  slot;
  dpf_pkg::slot_t  slot_next;
  dpf_pkg::frame_t frame;
  logic            load;

  // A new frame is loaded as the checksum beat leaves, so frames run back to back.
  assign load    = fifo_valid && (!busy || (pop && slot == dpf_pkg::SLOT_SUM));
  assign fifo_rd = load;
  assign empty   = !busy;

  always_comb begin
    case (slot)
      dpf_pkg::SLOT_SYNC: begin
        slot_next          = dpf_pkg::SLOT_DN_LO;
        frame_byte.tx_byte = dpf_pkg::SYNC_BYTE;
      end
      dpf_pkg::SLOT_DN_LO: begin
        slot_next          = dpf_pkg::SLOT_DN_HI;
        frame_byte.tx_byte = frame.dn[7:0];
      end
      dpf_pkg::SLOT_DN_HI: begin
        slot_next          = dpf_pkg::SLOT_DU_LO;
        frame_byte.tx_byte = frame.dn[15:8];
      end
      dpf_pkg::SLOT_DU_LO: begin
        slot_next          = dpf_pkg::SLOT_DU_HI;
        frame_byte.tx_byte = frame.du[7:0];
      end
      dpf_pkg::SLOT_DU_HI: begin
        slot_next          = dpf_pkg::SLOT_NUM;
        frame_byte.tx_byte = frame.du[15:8];
      end
      dpf_pkg::SLOT_NUM: begin
        slot_next          = dpf_pkg::SLOT_SUM;
        frame_byte.tx_byte = frame.number;
      end
      dpf_pkg::SLOT_SUM: begin
        slot_next          = dpf_pkg::SLOT_SYNC;
        frame_byte.tx_byte = frame.checksum;
      end
      default: begin
        slot_next          = dpf_pkg::SLOT_SYNC;
        frame_byte.tx_byte = dpf_pkg::SYNC_BYTE;
      end
    endcase
    frame_byte.last = (slot == dpf_pkg::SLOT_SUM);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= fifo_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      slot <= dpf_pkg::SLOT_SYNC;
    end else if (load) begin
      busy <= 1'b1;
      slot <= dpf_pkg::SLOT_SYNC;
    end else if (busy && pop) begin
      if (slot == dpf_pkg::SLOT_SUM) begin
        busy <= 1'b0;
      end
      slot <= slot_next;
    end
  end

`ifndef ASSERT_OFF
  a_load_starts_sync: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && slot == dpf_pkg::SLOT_SYNC)
    else $error("loaded frame does not start with the sync beat");
`endif

endmodule
